@@ hdl/hpl_pkg.sv @@
// shared constants, types and the cordic gain for the haversine path length unit
// no dependencies; imported by every module of the block
`default_nettype none

package hpl_pkg;

  localparam int FRAC     = 30;           // fraction bits of trig values and angles
  localparam int ANG_W    = 36;           // internal angle and trig width, signed
  localparam int RAD_W    = 32;           // stored radians, Q4.28
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int SEG_W    = 35;
  localparam int TOT_W    = 48;
  localparam int RADIUS_W = 23;
  localparam int R1K_W    = 33;           // radius times 1000
  localparam int MUL_W    = 33;           // shared multiplier operand width
  localparam int ITER_W   = 5;
  localparam int ROOT_W   = FRAC + 1;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // pi/180e6 in Q60, divided by 16 (its low four bits are zero)
  localparam logic [30:0] DEG_SCALE_C = 31'd1257642267;
  localparam int DEG_SHIFT = 28;

  localparam logic [R1K_W-1:0] R1K_RESET = 33'd6371000000;

  localparam logic signed [ANG_W-1:0] ONE_F     = 36'sd1073741824;
  localparam logic signed [ANG_W-1:0] PI_F      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] NEG_PI_F  = -36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_F = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] NEG_HALF_PI_F = -36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_F  = 36'sd6746518852;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [FRAC] = '{
    36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
    36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
    36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
    36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
    36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
    36'sd1024,      36'sd512,       36'sd256,       36'sd128,
    36'sd64,        36'sd32,        36'sd16,        36'sd8,
    36'sd4,         36'sd2
  };

  // item kinds decided at the front
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FIRST = 2'd1;
  localparam logic [1:0] KIND_SEG   = 2'd2;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [1:0]              kind;
  } hpl_item_t;

  typedef struct packed {
    logic                    start;
    logic                    vec;
    logic signed [ANG_W-1:0] x0;
    logic signed [ANG_W-1:0] y0;
    logic signed [ANG_W-1:0] z0;
  } hpl_cor_cmd_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } hpl_cor_rsp_t;

  typedef struct packed {
    logic            start;
    logic [FRAC:0]   a;
  } hpl_sq_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } hpl_sq_rsp_t;

  // start value of x that cancels the cordic gain, floor(2^2F / (G * 2^F)) with G the fixed-point gain
  function automatic logic signed [ANG_W-1:0] calc_gain();
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint r;
    longint q;
    x = longint'(1) <<< FRAC;
    y = 0;
    z = 0;
    for (int i = 0; i < FRAC; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    r = longint'(1) <<< FRAC;
    q = 0;
    for (int i = 0; i < FRAC; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= x) begin
        r = r - x;
        q = q | 1;
      end
    end
    return ANG_W'(q);
  endfunction

  localparam logic signed [ANG_W-1:0] K_GAIN = calc_gain();

endpackage

`default_nettype wire

@@ hdl/hpl_front.sv @@
// front part: accepts track points, classifies them and queues them for the back part
// depends on hpl_pkg
`default_nettype none

module hpl_front import hpl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic signed [LAT_W-1:0] latitude_i,
  input  logic signed [LON_W-1:0] longitude_i,
  input  logic                    track_start_i,
  output hpl_item_t               item_o,
  output logic                    item_valid_o,
  input  logic                    item_pop_i
);

  hpl_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              seen_q;
  logic              push_ok, pop_ok;
  hpl_item_t         in_item;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push_ok      = push_i && !full_o;
  assign pop_ok       = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    in_item.lat = latitude_i;
    in_item.lon = longitude_i;
    if (track_start_i) begin
      in_item.kind = KIND_START;
    end else if (seen_q) begin
      in_item.kind = KIND_SEG;
    end else begin
      in_item.kind = KIND_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_q   <= wr_q + 1'b1;
        seen_q <= 1'b1;
      end
      if (pop_ok) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/hpl_cordic.sv @@
// shared cordic unit, rotation and vectoring, one iteration per cycle
// depends on hpl_pkg (atan table, widths, command and response types)
`default_nettype none

module hpl_cordic import hpl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hpl_cor_cmd_t cmd_i,
  output hpl_cor_rsp_t rsp_o
);

  logic                    busy_q, done_q, vec_q;
  logic [ITER_W-1:0]       iter_q;
  logic signed [ANG_W-1:0] x_q, y_q, z_q;
  logic signed [ANG_W-1:0] dx, dy, x_d, y_d, z_d;
  logic                    ccw;

  assign dx  = y_q >>> iter_q;
  assign dy  = x_q >>> iter_q;
  // vectoring drives y toward zero, rotation drives z toward zero
  assign ccw = vec_q ? (y_q < 0) : (z_q >= 0);

  always_comb begin
    if (ccw) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - ATAN_TAB[iter_q];
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + ATAN_TAB[iter_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(FRAC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vec_q <= cmd_i.vec;
      x_q   <= cmd_i.x0;
      y_q   <= cmd_i.y0;
      z_q   <= cmd_i.z0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.x    = x_q;
  assign rsp_o.y    = y_q;
  assign rsp_o.z    = z_q;

endmodule

`default_nettype wire

@@ hdl/hpl_isqrt.sv @@
// digit-by-digit square root: largest r with floor(r*r / 2^F) <= a, two radicand bits a cycle
// depends on hpl_pkg
`default_nettype none

module hpl_isqrt import hpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hpl_sq_cmd_t cmd_i,
  output hpl_sq_rsp_t rsp_o
);

  localparam int RADN_W = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 4;

  logic                busy_q, done_q;
  logic [ITER_W-1:0]   cnt_q;
  logic [RADN_W-1:0]   radn_q;
  logic [REM_W-1:0]    rem_q, rem_sh, trial;
  logic [ROOT_W-1:0]   root_q;

  // r*r < (a+1)*2^F is the same test as r*r <= (a << F) + 2^F - 1
  assign rem_sh = {rem_q[REM_W-3:0], radn_q[RADN_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ITER_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      radn_q <= {1'b0, cmd_i.a, {FRAC{1'b1}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      radn_q <= {radn_q[RADN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

@@ hdl/hpl_back.sv @@
// back part: sequencer with shared multiplier, drives the cordic and square root units,
// accumulates the path total and holds the result register; depends on hpl_pkg
`default_nettype none

module hpl_back import hpl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hpl_item_t            item_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  input  logic                 cfg_valid_i,
  input  logic [RADIUS_W-1:0]  cfg_data_i,
  output hpl_cor_cmd_t         cor_cmd_o,
  input  hpl_cor_rsp_t         cor_rsp_i,
  output hpl_sq_cmd_t          sq_cmd_o,
  input  hpl_sq_rsp_t          sq_rsp_i,
  output logic                 out_valid_o,
  input  logic                 pop_i,
  output logic [SEG_W-1:0]     segment_mm_o,
  output logic [TOT_W-1:0]     total_mm_o,
  output logic                 segment_valid_o
);

  localparam int MUL_P = 2 * MUL_W;
  localparam int A_W   = MUL_W + 2;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MLAT = 5'd1;
  localparam logic [4:0] ST_MLON = 5'd2;
  localparam logic [4:0] ST_KIND = 5'd3;
  localparam logic [4:0] ST_C0   = 5'd4;
  localparam logic [4:0] ST_C1   = 5'd5;
  localparam logic [4:0] ST_C2   = 5'd6;
  localparam logic [4:0] ST_C3   = 5'd7;
  localparam logic [4:0] ST_M1   = 5'd8;
  localparam logic [4:0] ST_M2   = 5'd9;
  localparam logic [4:0] ST_M3   = 5'd10;
  localparam logic [4:0] ST_M4   = 5'd11;
  localparam logic [4:0] ST_M5   = 5'd12;
  localparam logic [4:0] ST_M6   = 5'd13;
  localparam logic [4:0] ST_SQ0  = 5'd14;
  localparam logic [4:0] ST_SQ1  = 5'd15;
  localparam logic [4:0] ST_VEC  = 5'd16;
  localparam logic [4:0] ST_F1   = 5'd17;
  localparam logic [4:0] ST_F2   = 5'd18;
  localparam logic [4:0] ST_DONE = 5'd19;

  localparam logic [FRAC:0]      ONE_A  = {1'b1, {FRAC{1'b0}}};
  localparam logic signed [A_W-1:0] ONE_AS = A_W'(ONE_F);
  localparam logic [MUL_P-1:0]   RAD_RND = MUL_P'(1) << (DEG_SHIFT - 1);

  function automatic logic [MUL_W-1:0] mag_of(input logic signed [ANG_W-1:0] v);
    logic [ANG_W-1:0] m;
    m = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
    return m[MUL_W-1:0];
  endfunction

  logic [4:0]              state_q, state_d;
  logic [1:0]              kind_q;
  logic signed [LAT_W-1:0] lat_raw_q;
  logic signed [LON_W-1:0] lon_raw_q;
  logic signed [RAD_W-1:0] lat_rad_q, lon_rad_q, prev_lat_q, prev_lon_q, rad_conv;
  logic [MUL_P-1:0]        mul_q, rad_rnd;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [LAT_W-1:0]        lat_mag;
  logic [LON_W-1:0]        lon_mag;
  logic signed [ANG_W-1:0] sd_q, sl_q, c1_q, c2_q, cos_res;
  logic                    neg_q;
  logic [MUL_W-1:0]        sq1_q, sq2_q, cc_q, prod_f;
  logic [FRAC:0]           a_q, a_cl;
  logic signed [A_W-1:0]   a_s;
  logic                    a_pos;
  logic [ROOT_W-1:0]       yroot_q;
  logic [MUL_W-1:0]        ang_q;
  logic [SEG_W-1:0]        seg_q, seg_fin;
  logic                    segv_q;
  logic [TOT_W-1:0]        total_q;
  logic [TOT_W:0]          total_sum;
  logic [R1K_W-1:0]        r1000_q;
  logic [MUL_P-FRAC+1:0]   d_rnd;
  logic signed [ANG_W-1:0] t_sel, t_red, t_fold;
  logic                    t_neg;
  logic                    out_valid_q, out_segv_q;
  logic [SEG_W-1:0]        out_seg_q;
  logic [TOT_W-1:0]        out_tot_q;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  assign lat_mag = lat_raw_q[LAT_W-1] ? LAT_W'(-lat_raw_q) : LAT_W'(lat_raw_q);
  assign lon_mag = lon_raw_q[LON_W-1] ? LON_W'(-lon_raw_q) : LON_W'(lon_raw_q);

  // microdegrees to radians: round half up on the magnitude, then apply the sign
  assign rad_rnd = mul_q + RAD_RND;

  always_comb begin
    logic [RAD_W-1:0] mg;
    logic             neg;
    mg  = RAD_W'(rad_rnd[DEG_SHIFT +: RAD_W-1]);
    neg = (state_q == ST_MLON) ? lat_raw_q[LAT_W-1] : lon_raw_q[LON_W-1];
    rad_conv = neg ? -$signed(mg) : $signed(mg);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MLAT: begin
        mul_a = MUL_W'(lat_mag);
        mul_b = MUL_W'(DEG_SCALE_C);
      end
      ST_MLON: begin
        mul_a = MUL_W'(lon_mag);
        mul_b = MUL_W'(DEG_SCALE_C);
      end
      ST_M1: begin
        mul_a = mag_of(sd_q);
        mul_b = mag_of(sd_q);
      end
      ST_M2: begin
        mul_a = mag_of(sl_q);
        mul_b = mag_of(sl_q);
      end
      ST_M3: begin
        mul_a = mag_of(c1_q);
        mul_b = mag_of(c2_q);
      end
      ST_M5: begin
        mul_a = cc_q;
        mul_b = sq2_q;
      end
      ST_F1: begin
        mul_a = ang_q;
        mul_b = r1000_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_f = mul_q[FRAC +: MUL_W];

  // angle fed to the cordic for the next rotation
  always_comb begin
    case (state_q)
      ST_KIND: t_sel = (ANG_W'(lat_rad_q) - ANG_W'(prev_lat_q)) <<< 1;
      ST_C0:   t_sel = (ANG_W'(lon_rad_q) - ANG_W'(prev_lon_q)) <<< 1;
      ST_C1:   t_sel = ANG_W'(prev_lat_q) <<< 2;
      ST_C2:   t_sel = ANG_W'(lat_rad_q) <<< 2;
      default: t_sel = '0;
    endcase
    if (t_sel > PI_F) begin
      t_red = t_sel - TWO_PI_F;
    end else if (t_sel < NEG_PI_F) begin
      t_red = t_sel + TWO_PI_F;
    end else begin
      t_red = t_sel;
    end
    // fold into the right half plane, cosine changes sign
    if (t_red > HALF_PI_F) begin
      t_fold = PI_F - t_red;
      t_neg  = 1'b1;
    end else if (t_red < NEG_HALF_PI_F) begin
      t_fold = NEG_PI_F - t_red;
      t_neg  = 1'b1;
    end else begin
      t_fold = t_red;
      t_neg  = 1'b0;
    end
  end

  assign cos_res = neg_q ? -cor_rsp_i.x : cor_rsp_i.x;

  // haversine term a, negative cosine product lowers it
  always_comb begin
    if (c1_q[ANG_W-1] != c2_q[ANG_W-1]) begin
      a_s = $signed(A_W'(sq1_q)) - $signed(A_W'(prod_f));
    end else begin
      a_s = $signed(A_W'(sq1_q)) + $signed(A_W'(prod_f));
    end
    a_pos = (a_s > 0);
    a_cl  = (a_s > ONE_AS) ? ONE_A : a_s[FRAC:0];
  end

  assign d_rnd   = (MUL_P-FRAC+2)'(mul_q[MUL_P-1:FRAC-1]) + 1'b1;
  assign seg_fin = d_rnd[SEG_W:1];

  assign total_sum = {1'b0, total_q} + (TOT_W+1)'(seg_q);

  always_comb begin
    cor_cmd_o.start = 1'b0;
    cor_cmd_o.vec   = 1'b0;
    cor_cmd_o.x0    = K_GAIN;
    cor_cmd_o.y0    = '0;
    cor_cmd_o.z0    = t_fold;
    sq_cmd_o.start  = 1'b0;
    sq_cmd_o.a      = a_cl;
    case (state_q)
      ST_KIND: cor_cmd_o.start = (kind_q == KIND_SEG);
      ST_C0, ST_C1, ST_C2: cor_cmd_o.start = cor_rsp_i.done;
      ST_M6: sq_cmd_o.start = a_pos;
      ST_SQ0: begin
        sq_cmd_o.start = sq_rsp_i.done;
        sq_cmd_o.a     = ONE_A - a_q;
      end
      ST_SQ1: begin
        cor_cmd_o.start = sq_rsp_i.done;
        cor_cmd_o.vec   = 1'b1;
        cor_cmd_o.x0    = ANG_W'({1'b0, sq_rsp_i.root});
        cor_cmd_o.y0    = ANG_W'({1'b0, yroot_q});
        cor_cmd_o.z0    = '0;
      end
      default: begin
        cor_cmd_o.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (item_valid_i) state_d = ST_MLAT;
      ST_MLAT: state_d = ST_MLON;
      ST_MLON: state_d = ST_KIND;
      ST_KIND: state_d = (kind_q == KIND_SEG) ? ST_C0 : ST_DONE;
      ST_C0:   if (cor_rsp_i.done) state_d = ST_C1;
      ST_C1:   if (cor_rsp_i.done) state_d = ST_C2;
      ST_C2:   if (cor_rsp_i.done) state_d = ST_C3;
      ST_C3:   if (cor_rsp_i.done) state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_M3;
      ST_M3:   state_d = ST_M4;
      ST_M4:   state_d = ST_M5;
      ST_M5:   state_d = ST_M6;
      ST_M6:   state_d = a_pos ? ST_SQ0 : ST_DONE;
      ST_SQ0:  if (sq_rsp_i.done) state_d = ST_SQ1;
      ST_SQ1:  if (sq_rsp_i.done) state_d = ST_VEC;
      ST_VEC:  if (cor_rsp_i.done) state_d = ST_F1;
      ST_F1:   state_d = ST_F2;
      ST_F2:   state_d = ST_DONE;
      ST_DONE: if (!out_valid_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
      total_q     <= '0;
      r1000_q     <= R1K_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        r1000_q <= (R1K_W'(cfg_data_i) << 10) - (R1K_W'(cfg_data_i) << 4)
                 - (R1K_W'(cfg_data_i) << 3);
      end
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE && !out_valid_q) begin
        out_valid_q <= 1'b1;
        prev_lat_q  <= lat_rad_q;
        prev_lon_q  <= lon_rad_q;
        case (kind_q)
          KIND_START: total_q <= '0;
          KIND_SEG:   total_q <= total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
          default:    total_q <= total_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        lat_raw_q <= item_i.lat;
        lon_raw_q <= item_i.lon;
        kind_q    <= item_i.kind;
      end
      ST_MLON: lat_rad_q <= rad_conv;
      ST_KIND: begin
        lon_rad_q <= rad_conv;
        seg_q     <= '0;
        segv_q    <= 1'b0;
        neg_q     <= t_neg;
      end
      ST_C0: if (cor_rsp_i.done) begin
        sd_q  <= cor_rsp_i.y;
        neg_q <= t_neg;
      end
      ST_C1: if (cor_rsp_i.done) begin
        sl_q  <= cor_rsp_i.y;
        neg_q <= t_neg;
      end
      ST_C2: if (cor_rsp_i.done) begin
        c1_q  <= cos_res;
        neg_q <= t_neg;
      end
      ST_C3: if (cor_rsp_i.done) c2_q <= cos_res;
      ST_M2: sq1_q <= prod_f;
      ST_M3: sq2_q <= prod_f;
      ST_M4: cc_q <= prod_f;
      ST_M6: begin
        a_q    <= a_cl;
        seg_q  <= '0;
        segv_q <= 1'b1;
      end
      ST_SQ0: if (sq_rsp_i.done) yroot_q <= sq_rsp_i.root;
      ST_VEC: if (cor_rsp_i.done) begin
        // central angle is twice the vectoring result, never negative
        ang_q <= cor_rsp_i.z[ANG_W-1] ? '0 : {cor_rsp_i.z[MUL_W-2:0], 1'b0};
      end
      ST_F2: seg_q <= seg_fin;
      ST_DONE: if (!out_valid_q) begin
        out_seg_q  <= seg_q;
        out_segv_q <= segv_q;
        case (kind_q)
          KIND_START: out_tot_q <= '0;
          KIND_SEG:   out_tot_q <= total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
          default:    out_tot_q <= total_q;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign segment_mm_o    = out_seg_q;
  assign total_mm_o      = out_tot_q;
  assign segment_valid_o = out_segv_q;

endmodule

`default_nettype wire

@@ hdl/haversine_path_length_unit.sv @@
// haversine path length unit: top level joining front queue, back sequencer, cordic and sqrt
// depends on hpl_pkg, hpl_front, hpl_back, hpl_cordic, hpl_isqrt
//
// Input side is a queue: a track point beat (latitude_i, longitude_i in signed
// microdegrees, track_start_i) is taken when push_i is high and full_o low.
// Result side is one register: while empty_o is low the result sits on
// segment_mm_o, total_mm_o and segment_valid_o; pop_i takes it.
// Each input beat yields exactly one result beat, in order.
// The radius register is written through cfg_valid_i / cfg_data_i (metres);
// cfg_ready_o is always high. Write it only while the block is idle.
// A point that starts a track or is the first one only passes the degree to
// radian conversion before its result; a measured segment also runs the
// shared cordic through four rotations and one vectoring pass of 30 iterations,
// two 31-step square roots, six multiply steps and the final scaling. A segment
// whose haversine term is not positive skips the roots and the vectoring pass.
// Points are worked one at a time, so the back part takes no new item before
// its result is stored; a two-entry input queue and one result register let
// both sides stall on their own. While the result is not popped the back part
// finishes its current point and then waits.
// Reset clears the previous point, the total and the queues, and sets the
// radius to 6371000 m.
`default_nettype none

module haversine_path_length_unit import hpl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic signed [LAT_W-1:0] latitude_i,
  input  logic signed [LON_W-1:0] longitude_i,
  input  logic                    track_start_i,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic [SEG_W-1:0]        segment_mm_o,
  output logic [TOT_W-1:0]        total_mm_o,
  output logic                    segment_valid_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [RADIUS_W-1:0]     cfg_data_i
);

  hpl_item_t    item;
  logic         item_valid, item_pop, out_valid;
  hpl_cor_cmd_t cor_cmd;
  hpl_cor_rsp_t cor_rsp;
  hpl_sq_cmd_t  sq_cmd;
  hpl_sq_rsp_t  sq_rsp;

  assign cfg_ready_o = 1'b1;
  assign empty_o     = !out_valid;

  hpl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .latitude_i    (latitude_i),
    .longitude_i   (longitude_i),
    .track_start_i (track_start_i),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  hpl_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .rsp_o  (cor_rsp)
  );

  hpl_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (sq_cmd),
    .rsp_o  (sq_rsp)
  );

  hpl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .cor_cmd_o       (cor_cmd),
    .cor_rsp_i       (cor_rsp),
    .sq_cmd_o        (sq_cmd),
    .sq_rsp_i        (sq_rsp),
    .out_valid_o     (out_valid),
    .pop_i           (pop_i),
    .segment_mm_o    (segment_mm_o),
    .total_mm_o      (total_mm_o),
    .segment_valid_o (segment_valid_o)
  );

`ifndef NO_ASSERTIONS
  a_cordic_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_cmd.start |-> !cor_rsp.busy)
    else $error("cordic restarted while busy");

  a_sqrt_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_cmd.start |-> !sq_rsp.busy)
    else $error("square root restarted while busy");

  a_no_segment_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !segment_valid_o) |-> (segment_mm_o == '0))
    else $error("unmeasured point carries a segment length");

  a_pop_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("back part took an item from an empty queue");
`endif

endmodule

`default_nettype wire
